// File: rtl/multi_queue_shared_buffer_core_macros.svh
// Assertion macros used by the queue controller RTL.
`ifndef MULTI_QUEUE_SHARED_BUFFER_CORE_MACROS_SVH
`define MULTI_QUEUE_SHARED_BUFFER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define MQSB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define MQSB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("implication failed");

`else

`define MQSB_ASSERT(lbl, clk, rst_n, prop)

`define MQSB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/mqsb_pkg.sv
`default_nettype none

package mqsb_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned QidxWidth = 2;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic                        req_type;
    logic [QidxWidth-1:0]        queue_index;
    logic signed [DataWidth-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] data_out;
    status_e                     status;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/mqsb_ram.sv
`default_nettype none

module mqsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/mqsb_ctrl.sv
`default_nettype none

`include "multi_queue_shared_buffer_core_macros.svh"

module mqsb_ctrl
  import mqsb_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned QUEUES  = 4,
  localparam int unsigned AW     = $clog2(ENTRIES),
  localparam int unsigned PW     = $clog2(ENTRIES + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire req_t                 in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output rsp_t                      out_data_o,
  output logic                      rd_en_o,
  output logic [AW-1:0]             rd_addr_o,
  input  wire logic [PW-1:0]        link_rd_i,
  input  wire logic [DataWidth-1:0] data_rd_i,
  output logic                      link_wr_en_o,
  output logic [AW-1:0]             link_wr_addr_o,
  output logic [PW-1:0]             link_wr_data_o,
  output logic                      data_wr_en_o,
  output logic [AW-1:0]             data_wr_addr_o,
  output logic [DataWidth-1:0]      data_wr_data_o
);

  // Only the queues that the request field can name get pointer registers.
  localparam int unsigned MaxQ = 1 << QidxWidth;
  localparam int unsigned NQ   = (QUEUES < MaxQ) ? QUEUES : MaxQ;
  localparam int unsigned QW   = (NQ > 1) ? $clog2(NQ) : 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                 state_q, state_d;
  logic                 req_q;
  logic [QidxWidth-1:0] qidx_q;
  logic [DataWidth-1:0] din_q;
  logic                 ok_q;
  logic                 fresh_q;
  logic [PW-1:0]        e_q;
  logic [PW-1:0]        head_q [NQ];
  logic [PW-1:0]        tail_q [NQ];
  logic [PW-1:0]        free_head_q, free_head_d;
  logic [PW-1:0]        fill_q, fill_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 out_data_q, out_data_d;

  logic          accept;
  logic          fire;
  logic          q_ok;
  logic [QW-1:0] qi;
  logic [QW-1:0] qe;
  logic [PW-1:0] sel_head;
  logic          acc_ok;
  logic [PW-1:0] acc_e;
  logic [PW-1:0] nx;
  logic          head_wr;
  logic [PW-1:0] head_wr_data;
  logic          tail_wr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  assign q_ok     = int'(in_data_i.queue_index) < int'(NQ);
  assign qi       = in_data_i.queue_index[QW-1:0];
  assign qe       = qidx_q[QW-1:0];
  assign sel_head = q_ok ? head_q[qi] : NIL;

  always_comb begin
    if (in_data_i.req_type == REQ_PUSH) begin
      acc_ok = q_ok && (free_head_q < NIL);
      acc_e  = free_head_q;
    end else begin
      acc_ok = q_ok && (sel_head < NIL);
      acc_e  = sel_head;
    end
  end

  assign rd_en_o   = accept && acc_ok;
  assign rd_addr_o = acc_e[AW-1:0];

  always_comb begin
    state_d        = state_q;
    free_head_d    = free_head_q;
    fill_d         = fill_q;
    out_valid_d    = out_valid_q;
    out_data_d     = out_data_q;
    head_wr        = 1'b0;
    head_wr_data   = e_q;
    tail_wr        = 1'b0;
    link_wr_en_o   = 1'b0;
    link_wr_addr_o = e_q[AW-1:0];
    link_wr_data_o = free_head_q;
    data_wr_en_o   = 1'b0;
    data_wr_addr_o = e_q[AW-1:0];
    data_wr_data_o = din_q;
    nx             = fresh_q ? (e_q + PW'(1)) : link_rd_i;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      state_d = ST_EXEC;
    end

    if (fire) begin
      state_d             = ST_IDLE;
      out_valid_d         = 1'b1;
      out_data_d.data_out = '0;
      out_data_d.status   = STATUS_OK;
      if (!ok_q) begin
        out_data_d.status = (req_q == REQ_PUSH) ? STATUS_OVERFLOW : STATUS_UNDERFLOW;
      end else if (req_q == REQ_PUSH) begin
        // Entries at or above the fill count were never written; their link is the next entry.
        free_head_d  = (nx < NIL) ? nx : NIL;
        if (fresh_q) begin
          fill_d = fill_q + PW'(1);
        end
        if (head_q[qe] < NIL) begin
          link_wr_en_o   = 1'b1;
          link_wr_addr_o = tail_q[qe][AW-1:0];
          link_wr_data_o = e_q;
        end else begin
          head_wr = 1'b1;
        end
        tail_wr      = 1'b1;
        data_wr_en_o = 1'b1;
      end else begin
        // The tail entry ends its queue whatever its link holds.
        head_wr             = 1'b1;
        head_wr_data        = ((e_q == tail_q[qe]) || !(link_rd_i < NIL)) ? NIL : link_rd_i;
        link_wr_en_o        = 1'b1;
        free_head_d         = e_q;
        out_data_d.data_out = data_rd_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_head_q <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < int'(NQ); i++) begin
        head_q[i] <= NIL;
      end
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (head_wr) begin
        head_q[qe] <= head_wr_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (tail_wr) begin
      tail_q[qe] <= e_q;
    end
    if (accept) begin
      req_q   <= in_data_i.req_type;
      qidx_q  <= in_data_i.queue_index;
      din_q   <= in_data_i.data_in;
      ok_q    <= acc_ok;
      e_q     <= acc_e;
      fresh_q <= (acc_e == fill_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `MQSB_ASSERT_IMPL(a_accept_exec, clk_i, rst_ni, accept, state_q == ST_EXEC)
  `MQSB_ASSERT_IMPL(a_fire_valid, clk_i, rst_ni, fire, out_valid_q && state_q == ST_IDLE)
  `MQSB_ASSERT(a_free_head_range, clk_i, rst_ni, free_head_q <= NIL)
  `MQSB_ASSERT(a_fill_step, clk_i, rst_ni,
               $stable(fill_q) || (fill_q == $past(fill_q) + PW'(1)))

endmodule

`default_nettype wire

// File: rtl/multi_queue_shared_buffer_core.sv
// Shared-buffer multi-queue: up to four FIFO queues chained through one store of
// ENTRIES data words, with unused entries on a linked free list. Each request
// produces exactly one response with status ok, overflow (store full or queue
// number beyond QUEUES on a push) or underflow (queue empty or number beyond
// QUEUES on a pop). A request first reads the link and data memories at the
// chosen entry, then updates the pointers and writes back. The response sits
// in an output register, so a new request is taken while the previous response
// waits; only a stalled response holding the register delays the update. No
// clearing pass follows reset: a fill count stands for the initial free chain.
`default_nettype none

module multi_queue_shared_buffer_core
  import mqsb_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned QUEUES  = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_data_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned PW = $clog2(ENTRIES + 1);

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [PW-1:0]        link_rd;
  logic [DataWidth-1:0] data_rd;
  logic                 link_wr_en;
  logic [AW-1:0]        link_wr_addr;
  logic [PW-1:0]        link_wr_data;
  logic                 data_wr_en;
  logic [AW-1:0]        data_wr_addr;
  logic [DataWidth-1:0] data_wr_data;

  mqsb_ctrl #(
    .ENTRIES(ENTRIES),
    .QUEUES (QUEUES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .link_rd_i     (link_rd),
    .data_rd_i     (data_rd),
    .link_wr_en_o  (link_wr_en),
    .link_wr_addr_o(link_wr_addr),
    .link_wr_data_o(link_wr_data),
    .data_wr_en_o  (data_wr_en),
    .data_wr_addr_o(data_wr_addr),
    .data_wr_data_o(data_wr_data)
  );

  mqsb_ram #(
    .WIDTH(PW),
    .DEPTH(ENTRIES)
  ) u_link_ram (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(link_rd),
    .wr_en_i  (link_wr_en),
    .wr_addr_i(link_wr_addr),
    .wr_data_i(link_wr_data)
  );

  mqsb_ram #(
    .WIDTH(DataWidth),
    .DEPTH(ENTRIES)
  ) u_data_ram (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(data_rd),
    .wr_en_i  (data_wr_en),
    .wr_addr_i(data_wr_addr),
    .wr_data_i(data_wr_data)
  );

endmodule

`default_nettype wire

// File: sim/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mqsb_pkg::*;

  localparam int NENT = 16;
  localparam int NQ   = 4;
  localparam logic [4:0] NIL = 5'd16;

  typedef struct {
    bit          drain;
    int unsigned gap;
    req_t        req;
  } cmd_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  req_t in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  cmd_t cmd_q[$];
  rsp_t want_q[$];
  rsp_t want;
  int   errors = 0;
  int   n_done = 0;
  int   hold = 0;
  bit   long_hold_done = 1'b0;

  logic [4:0]  front_ptr[NQ];
  logic [3:0]  back_ptr[NQ];
  logic [4:0]  chain[NENT];
  logic [31:0] word_mem[NENT];
  logic [4:0]  free_ptr;

  multi_queue_shared_buffer_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void clear_queues();
    for (int i = 0; i < NQ; i++) begin
      front_ptr[i] = NIL;
      back_ptr[i]  = '0;
    end
    for (int i = 0; i < NENT; i++) begin
      chain[i]    = 5'(i + 1);
      word_mem[i] = '0;
    end
    chain[NENT-1] = NIL;
    free_ptr      = '0;
  endfunction

  function automatic rsp_t serve_request(req_t r);
    rsp_t       res;
    logic [4:0] e;
    logic [4:0] nx;
    int         q;
    q            = int'(r.queue_index);
    res.data_out = '0;
    res.status   = STATUS_OK;
    if (r.req_type == REQ_PUSH) begin
      if (q >= NQ || free_ptr >= NENT) begin
        res.status = STATUS_OVERFLOW;
      end else begin
        e        = free_ptr;
        nx       = chain[e];
        free_ptr = (nx < NENT) ? nx : NIL;
        if (front_ptr[q] >= NENT) begin
          front_ptr[q] = e;
        end else begin
          chain[back_ptr[q]] = e;
        end
        chain[e]    = NIL;
        back_ptr[q] = e[3:0];
        word_mem[e] = r.data_in;
      end
    end else begin
      if (q >= NQ || front_ptr[q] >= NENT) begin
        res.status = STATUS_UNDERFLOW;
      end else begin
        e            = front_ptr[q];
        nx           = chain[e];
        front_ptr[q] = (nx < NENT) ? nx : NIL;
        chain[e]     = free_ptr;
        free_ptr     = e;
        res.data_out = word_mem[e];
      end
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_cmd(logic kind, logic [1:0] q, logic [31:0] d, int unsigned g);
    cmd_t c;
    c.drain           = 1'b0;
    c.gap             = g;
    c.req.req_type    = kind;
    c.req.queue_index = q;
    c.req.data_in     = d;
    cmd_q.push_back(c);
  endfunction

  function automatic void add_drain();
    cmd_t c;
    c.drain = 1'b1;
    c.gap   = 0;
    c.req   = '0;
    cmd_q.push_back(c);
  endfunction

  // Sender: the head of the command queue is either a request, preceded by its idle gap,
  // or a marker that holds the sender back until every outstanding response is in.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        want_q.push_back(serve_request(in_data_i));
      end
      if (cmd_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (cmd_q[0].drain) begin
        if (want_q.size() == 0) begin
          void'(cmd_q.pop_front());
        end
        in_valid_i <= 1'b0;
      end else if (cmd_q[0].gap > 0) begin
        cmd_q[0].gap--;
        in_valid_i <= 1'b0;
      end else begin
        in_data_i  <= cmd_q[0].req;
        in_valid_i <= 1'b1;
        void'(cmd_q.pop_front());
      end
    end
  end

  // Receiver: checks each response transfer and stalls at random, with one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_done++;
        if (want_q.size() == 0) begin
          $display("%0t: unexpected response, data_out %h status %0d", $time,
                   out_data_o.data_out, out_data_o.status);
          errors++;
        end else begin
          want = want_q.pop_front();
          if (out_data_o.data_out !== want.data_out) begin
            $display("%0t: data_out mismatch, expected %h actual %h", $time,
                     want.data_out, out_data_o.data_out);
            errors++;
          end
          if (out_data_o.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d", $time,
                     want.status, out_data_o.status);
            errors++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (n_done >= 150 && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold = 400;
        out_ready_i <= 1'b0;
      end else if (n_done >= 250 && n_done < 320) begin
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 99) < 25) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int          made;
    int          len;
    int          mode;
    bit          calm;
    logic        kind;
    int unsigned g;

    clear_queues();

    add_cmd(REQ_POP, 2'd0, 32'h1234_5678, 0);
    add_cmd(REQ_PUSH, 2'd0, 32'h7FFF_FFFF, 0);
    add_cmd(REQ_PUSH, 2'd1, 32'h8000_0000, 0);
    add_cmd(REQ_PUSH, 2'd2, 32'h0000_0000, 0);
    add_cmd(REQ_PUSH, 2'd3, 32'hFFFF_FFFF, 0);
    add_cmd(REQ_PUSH, 2'd0, 32'h5555_AAAA, 0);
    add_cmd(REQ_POP, 2'd3, 32'hFFFF_FFFF, 0);
    add_cmd(REQ_POP, 2'd2, 32'h0000_0000, 1);
    add_cmd(REQ_POP, 2'd1, 32'h0000_0000, 0);
    add_cmd(REQ_POP, 2'd0, 32'h0000_0000, 2);
    add_cmd(REQ_POP, 2'd0, 32'h0000_0000, 0);
    add_cmd(REQ_POP, 2'd0, 32'h0000_0000, 0);
    add_cmd(REQ_POP, 2'd3, 32'h0000_0000, 0);
    add_cmd(REQ_PUSH, 2'd2, 32'hAAAA_5555, 0);
    add_cmd(REQ_PUSH, 2'd2, 32'h0000_0001, 0);
    add_cmd(REQ_POP, 2'd2, 32'h0000_0000, 0);
    add_cmd(REQ_POP, 2'd2, 32'h0000_0000, 0);
    add_drain();

    made = 0;
    while (made < 450) begin
      mode = $urandom_range(0, 9);
      len  = $urandom_range(6, 24);
      calm = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
        if (mode < 3) begin
          kind = REQ_PUSH;
        end else if (mode < 5) begin
          kind = REQ_POP;
        end else begin
          kind = ($urandom_range(0, 99) < 55) ? REQ_PUSH : REQ_POP;
        end
        g = calm ? 0 : pick_gap();
        add_cmd(kind, 2'($urandom_range(0, 3)), pick_word(), g);
      end
      if (made < 300 && made + len >= 300) begin
        add_drain();
      end
      made += len;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (want_q.size() != 0) begin
      $display("%0t: %0d responses still outstanding", $time, want_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: multi_queue_shared_buffer_core.f
+incdir+rtl
rtl/mqsb_pkg.sv
rtl/mqsb_ram.sv
rtl/mqsb_ctrl.sv
rtl/multi_queue_shared_buffer_core.sv
sim/testbench.sv
